// ----- rtl/msdp_pkg.sv -----
// Package for the minimum vertical seam block: controller states and command/status structs.
// No dependencies.
package msdp_pkg;

  localparam int unsigned SUM_W    = 21;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COLF_W   = 6;
  localparam int unsigned CFG_W    = 7;
  localparam logic [0:0]  CFG_COLS = 1'b0;
  localparam logic [0:0]  CFG_ROWS = 1'b1;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [1:0] BP_LEFT  = 2'd0;
  localparam logic [1:0] BP_UP    = 2'd1;
  localparam logic [1:0] BP_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_COPY,
    ST_MIN,
    ST_TRACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic copy_en;
    logic copy_clr;
    logic min_en;
    logic min_clr;
    logic trace_start;
    logic trace_en;
    logic emit_en;
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic img_done;
    logic copy_done;
    logic trace_done;
    logic emit_done;
  } stat_t;

endpackage

// ----- rtl/min_seam_dynamic_programming_top.sv -----
// Top level of the minimum vertical seam block: config registers, controller, datapath.
// Depends on msdp_pkg, msdp_ctrl, msdp_datapath.
//
//  channel   ports                                          handshake
//  input     in_pixel_cost                                  start & !busy
//  result    out_row_number, out_seam_column,               out_valid, one cycle
//            out_total_cost, out_last_of_seam
//  config    cfg_we, cfg_index, cfg_wdata                   cfg_we
//
// One pixel per cycle within a row. After each row but the last the block is busy while the
// row sums shift into the previous-row window. After the last pixel it runs the minimum
// search, then the traceback, then the emit of one result per row; each result shows in the
// cycle after its emit cycle.
// Reset is synchronous; the receiver cannot stall.
module min_seam_dynamic_programming_top #(
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned MAX_ROWS  = 32,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [COST_BITS-1:0]        in_pixel_cost,
  output logic                        out_valid,
  output logic [msdp_pkg::ROW_W-1:0]  out_row_number,
  output logic [msdp_pkg::COLF_W-1:0] out_seam_column,
  output logic [msdp_pkg::SUM_W-1:0]  out_total_cost,
  output logic                        out_last_of_seam,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [msdp_pkg::CFG_W-1:0]  cfg_wdata
);
  localparam int unsigned CCW = $clog2(MAX_COLS+1);
  localparam int unsigned RCW = $clog2(MAX_ROWS+1);

  logic [6:0] cols_r;
  logic [5:0] rows_r;
  logic [CCW-1:0] cols_eff;
  logic [RCW-1:0] rows_eff;
  logic cfg_clear;
  msdp_pkg::cmd_t  cmd;
  msdp_pkg::stat_t stat;

  // Hold config registers; any write restarts the image.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 7'd64;
      rows_r <= 6'd32;
    end else if (cfg_we) begin
      if (cfg_index == msdp_pkg::CFG_COLS) cols_r <= cfg_wdata;
      else rows_r <= cfg_wdata[5:0];
    end
  end
  assign cfg_clear = cfg_we;

  // Saturate into the supported ranges.
  always_comb begin
    if (cols_r < 7'd2) cols_eff = CCW'(2);
    else if (32'(cols_r) > MAX_COLS) cols_eff = CCW'(MAX_COLS);
    else cols_eff = CCW'(cols_r);
    if (rows_r < 6'd1) rows_eff = RCW'(1);
    else if (32'(rows_r) > MAX_ROWS) rows_eff = RCW'(MAX_ROWS);
    else rows_eff = RCW'(rows_r);
  end

  msdp_ctrl u_ctrl (
    .clk, .rst_n, .start, .cfg_clear, .stat, .cmd, .busy
  );

  msdp_datapath #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .COST_BITS(COST_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_clear, .cols_eff, .rows_eff,
    .cost(in_pixel_cost), .out_valid, .out_row_number, .out_seam_column,
    .out_total_cost, .out_last_of_seam
  );
endmodule

// ----- rtl/msdp_datapath.sv -----
// Datapath: row sum buffers, back-pointer memory, minimum search, traceback, result output.
// Depends on msdp_pkg.
module msdp_datapath #(
  parameter int unsigned MAX_COLS  = 64,
  parameter int unsigned MAX_ROWS  = 32,
  parameter int unsigned COST_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  msdp_pkg::cmd_t              cmd,
  output msdp_pkg::stat_t             stat,
  input  logic                        cfg_clear,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols_eff,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows_eff,
  input  logic [COST_BITS-1:0]        cost,
  output logic                        out_valid,
  output logic [msdp_pkg::ROW_W-1:0]  out_row_number,
  output logic [msdp_pkg::COLF_W-1:0] out_seam_column,
  output logic [msdp_pkg::SUM_W-1:0]  out_total_cost,
  output logic                        out_last_of_seam
);
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SW = msdp_pkg::SUM_W;
  localparam int unsigned CCW = $clog2(MAX_COLS+1);
  localparam int unsigned RCW = $clog2(MAX_ROWS+1);

  // Previous-row sums sit in a shift register read at fixed taps; current row in a memory.
  logic [SW-1:0] pr_sr [MAX_COLS];
  logic [SW-1:0] pl_r;
  logic [SW-1:0] cur_mem [MAX_COLS];
  logic [1:0]    bp_mem [2**(RW+CW)];
  logic [CW-1:0] seam_mem [MAX_ROWS];

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] best_sum_r;
  logic [CW-1:0] best_col_r, best_col_nxt;
  logic          take_min;
  logic [SW-1:0] cur_rd_r;
  logic          cp_vld_r;
  logic          mn_vld_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] tcol_r;
  logic [RW-1:0] trow_r;
  logic [1:0]    bp_rd_r;
  logic          bp_vld_r;
  logic [RW-1:0] erow_r;

  logic [CCW-1:0] cols_m1;
  logic [RCW-1:0] rows_m1;
  logic           last_col, last_row;
  logic           pr_shift;
  logic [SW-1:0]  up_l, up_c, up_r, best;
  logic [1:0]     bp;
  logic [SW:0]    sum_w;
  logic [SW-1:0]  sum;

  assign cols_m1  = cols_eff - CCW'(1);
  assign rows_m1  = rows_eff - RCW'(1);
  assign last_col = (CCW'(col_r) == cols_m1);
  assign last_row = (RCW'(row_r) == rows_m1);

  // Pick the smallest of up to three neighbors, lowest column on ties.
  always_comb begin
    up_l = pl_r;
    up_c = pr_sr[0];
    up_r = pr_sr[1];
    if (row_r == '0) begin
      best = '0;
      bp   = msdp_pkg::BP_UP;
    end else begin
      if (col_r == '0) begin
        best = up_c;
        bp   = msdp_pkg::BP_UP;
      end else begin
        best = up_l;
        bp   = msdp_pkg::BP_LEFT;
        if (up_c < best) begin
          best = up_c;
          bp   = msdp_pkg::BP_UP;
        end
      end
      if (!last_col && up_r < best) begin
        best = up_r;
        bp   = msdp_pkg::BP_RIGHT;
      end
    end
    sum_w = {1'b0, best} + (SW+1)'(cost);
    sum   = sum_w[SW] ? msdp_pkg::SUM_MAX : sum_w[SW-1:0];
  end

  // Advance pixel counters.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    if (cfg_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.copy_clr || cmd.min_clr) idx_nxt = '0;
    else if (cmd.copy_en || cmd.min_en) idx_nxt = idx_r + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      idx_r    <= '0;
      cp_vld_r <= 1'b0;
      mn_vld_r <= 1'b0;
      bp_vld_r <= 1'b0;
      erow_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      idx_r    <= idx_nxt;
      cp_vld_r <= cmd.copy_en && !stat.copy_done;
      mn_vld_r <= cmd.min_en && !stat.copy_done;
      bp_vld_r <= cmd.trace_en && !bp_vld_r && (trow_r != '0);
      if (cmd.trace_start) erow_r <= '0;
      else if (cmd.emit_en) erow_r <= erow_r + RW'(1);
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_mem[col_r] <= sum;
      bp_mem[{row_r, col_r}] <= bp;
    end
    cur_rd_r <= cur_mem[idx_r];
    rd_idx_r <= idx_r;
    bp_rd_r  <= bp_mem[{trow_r, tcol_r}];
  end

  // Shift the previous-row window on each pixel; refill it from the current row.
  assign pr_shift = cmd.accept || cp_vld_r;

  always_ff @(posedge clk) begin
    if (pr_shift) begin
      for (int unsigned i = 0; i < MAX_COLS - 1; i++) pr_sr[i] <= pr_sr[i+1];
      pr_sr[MAX_COLS-1] <= cur_rd_r;
      pl_r <= pr_sr[0];
    end
  end

  // Track the leftmost minimum of the bottom row.
  always_comb begin
    take_min     = mn_vld_r && (rd_idx_r == '0 || cur_rd_r < best_sum_r);
    best_col_nxt = take_min ? rd_idx_r : best_col_r;
  end

  // Leftmost minimum of the bottom row, then traceback.
  always_ff @(posedge clk) begin
    if (cmd.min_clr) begin
      best_sum_r <= msdp_pkg::SUM_MAX;
      best_col_r <= '0;
    end else if (take_min) begin
      best_sum_r <= cur_rd_r;
      best_col_r <= rd_idx_r;
    end
    if (cmd.trace_start) begin
      tcol_r <= best_col_nxt;
      trow_r <= RW'(rows_m1);
      seam_mem[RW'(rows_m1)] <= best_col_nxt;
    end else if (bp_vld_r) begin
      if (bp_rd_r == msdp_pkg::BP_LEFT && tcol_r != '0) begin
        tcol_r <= tcol_r - CW'(1);
        seam_mem[trow_r - RW'(1)] <= tcol_r - CW'(1);
      end else if (bp_rd_r == msdp_pkg::BP_RIGHT && CCW'(tcol_r) != cols_m1) begin
        tcol_r <= tcol_r + CW'(1);
        seam_mem[trow_r - RW'(1)] <= tcol_r + CW'(1);
      end else begin
        seam_mem[trow_r - RW'(1)] <= tcol_r;
      end
      trow_r <= trow_r - RW'(1);
    end
  end

  // Register each result for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit_en;
    end
    out_row_number   <= msdp_pkg::ROW_W'(erow_r);
    out_seam_column  <= msdp_pkg::COLF_W'(seam_mem[erow_r]);
    out_total_cost   <= best_sum_r;
    out_last_of_seam <= (RCW'(erow_r) == rows_m1);
  end

  assign stat.row_done   = cmd.accept && last_col && !last_row;
  assign stat.img_done   = cmd.accept && last_col && last_row;
  assign stat.copy_done  = (cp_vld_r && rd_idx_r == CW'(MAX_COLS - 1)) ||
                           (mn_vld_r && CCW'(rd_idx_r) == cols_m1);
  assign stat.trace_done = (trow_r == '0) && !bp_vld_r;
  assign stat.emit_done  = (RCW'(erow_r) == rows_m1);

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> CCW'(col_r) < cols_eff) else $error("column counter past row end");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> RCW'(row_r) < rows_eff) else $error("row counter past image end");
  a_sweep_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cp_vld_r && mn_vld_r)) else $error("copy and minimum sweeps overlap");
endmodule

// ----- rtl/msdp_ctrl.sv -----
// Controller state machine: sequences pixel fill, row copy, minimum search, traceback, emit.
// Depends on msdp_pkg.
module msdp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            cfg_clear,
  input  msdp_pkg::stat_t stat,
  output msdp_pkg::cmd_t  cmd,
  output logic            busy
);
  msdp_pkg::state_t state_r, state_nxt;
  logic             tr_wait_r, tr_wait_nxt;

  // Next state.
  always_comb begin
    state_nxt   = state_r;
    tr_wait_nxt = 1'b0;
    case (state_r)
      msdp_pkg::ST_FILL: begin
        if (stat.row_done) state_nxt = msdp_pkg::ST_COPY;
        else if (stat.img_done) state_nxt = msdp_pkg::ST_MIN;
      end
      msdp_pkg::ST_COPY: begin
        if (stat.copy_done) state_nxt = msdp_pkg::ST_FILL;
      end
      msdp_pkg::ST_MIN: begin
        if (stat.copy_done) begin
          state_nxt   = msdp_pkg::ST_TRACE;
          tr_wait_nxt = 1'b1;
        end
      end
      msdp_pkg::ST_TRACE: begin
        if (!tr_wait_r && stat.trace_done) state_nxt = msdp_pkg::ST_EMIT;
      end
      msdp_pkg::ST_EMIT: begin
        if (stat.emit_done) state_nxt = msdp_pkg::ST_FILL;
      end
      default: state_nxt = msdp_pkg::ST_FILL;
    endcase
    if (cfg_clear) state_nxt = msdp_pkg::ST_FILL;
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      msdp_pkg::ST_FILL: begin
        busy       = 1'b0;
        cmd.accept = start;
        cmd.copy_clr = 1'b1;
      end
      msdp_pkg::ST_COPY: cmd.copy_en = 1'b1;
      msdp_pkg::ST_MIN: begin
        cmd.min_en = 1'b1;
        cmd.trace_start = stat.copy_done;
      end
      msdp_pkg::ST_TRACE: begin
        cmd.trace_en = !tr_wait_r && !stat.trace_done;
      end
      msdp_pkg::ST_EMIT: cmd.emit_en = 1'b1;
      default: cmd = '0;
    endcase
    if (state_r == msdp_pkg::ST_FILL && stat.img_done) cmd.min_clr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= msdp_pkg::ST_FILL;
      tr_wait_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tr_wait_r <= tr_wait_nxt;
    end
  end

  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |-> state_r == msdp_pkg::ST_EMIT) else $error("emit outside emit state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !cmd.accept) else $error("accept while busy");
  a_copy_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msdp_pkg::ST_COPY && stat.copy_done && !cfg_clear) |=>
      state_r == msdp_pkg::ST_FILL) else $error("copy did not return to fill");
endmodule

// ----- bench/min_seam_dynamic_programming_top_tb.sv -----
// Testbench for min_seam_dynamic_programming_top: streams pixel-cost images and checks seams.
// Depends on msdp_pkg and the RTL top; the expected seams come from an in-bench predictor.
module min_seam_dynamic_programming_top_tb;

  localparam int unsigned LIM_COLS = 64;
  localparam int unsigned LIM_ROWS = 32;
  localparam int unsigned WATCHDOG = 5000;
  localparam int unsigned QUIET_AT = 330;

  typedef struct packed {
    logic [msdp_pkg::ROW_W-1:0]  row;
    logic [msdp_pkg::COLF_W-1:0] col;
    logic [msdp_pkg::SUM_W-1:0]  total;
    logic                        last;
  } seam_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [15:0]                 in_pixel_cost = '0;
  logic                        out_valid;
  logic [msdp_pkg::ROW_W-1:0]  out_row_number;
  logic [msdp_pkg::COLF_W-1:0] out_seam_column;
  logic [msdp_pkg::SUM_W-1:0]  out_total_cost;
  logic                        out_last_of_seam;
  logic                        cfg_we = 1'b0;
  logic                        cfg_index = msdp_pkg::CFG_COLS;
  logic [msdp_pkg::CFG_W-1:0]  cfg_wdata = '0;

  min_seam_dynamic_programming_top uut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [6:0]                 cols_reg = 7'd64;
  logic [5:0]                 rows_reg = 6'd32;
  logic [msdp_pkg::SUM_W-1:0] prev_sums [LIM_COLS];
  logic [msdp_pkg::SUM_W-1:0] cur_sums [LIM_COLS];
  logic [1:0]                 ptrs [LIM_COLS*LIM_ROWS];
  int unsigned                row_pos = 0, col_pos = 0;

  logic [15:0] pixel_q [$];
  seam_row_t   seam_q [$];
  int unsigned pixels_pushed = 0, pixels_taken = 0;
  int unsigned errors = 0, gap_left = 0, quiet_cycles = 0;

  function automatic int unsigned cols_now();
    return (cols_reg < 2) ? 2 : (cols_reg > LIM_COLS) ? LIM_COLS : cols_reg;
  endfunction

  function automatic int unsigned rows_now();
    return (rows_reg < 1) ? 1 : (rows_reg > LIM_ROWS) ? LIM_ROWS : rows_reg;
  endfunction

  // Advance the DP by one pixel; on the last pixel trace back and queue the seam.
  function automatic void predict_pixel(logic [15:0] cost);
    int unsigned cols, rows, r, c, best, sum, col, i;
    logic [1:0] bp;
    int unsigned path [LIM_ROWS];
    seam_row_t rec;
    cols = cols_now();
    rows = rows_now();
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    if (r == 0) begin
      best = 0; bp = msdp_pkg::BP_UP;
    end else begin
      if (c == 0) begin
        best = prev_sums[0]; bp = msdp_pkg::BP_UP;
      end else begin
        best = prev_sums[c-1]; bp = msdp_pkg::BP_LEFT;
        if (prev_sums[c] < best) begin best = prev_sums[c]; bp = msdp_pkg::BP_UP; end
      end
      if (c + 1 < cols && prev_sums[c+1] < best) begin
        best = prev_sums[c+1]; bp = msdp_pkg::BP_RIGHT;
      end
    end
    sum = best + cost;
    if (sum > msdp_pkg::SUM_MAX) sum = msdp_pkg::SUM_MAX;
    cur_sums[c] = msdp_pkg::SUM_W'(sum);
    ptrs[r*LIM_COLS + c] = bp;
    if (c + 1 < cols) begin
      col_pos = c + 1; row_pos = r;
      return;
    end
    col_pos = 0;
    if (r + 1 < rows) begin
      prev_sums = cur_sums;
      row_pos = r + 1;
      return;
    end
    row_pos = 0;
    col = 0;
    for (i = 1; i < cols; i++) if (cur_sums[i] < cur_sums[col]) col = i;
    sum = cur_sums[col];
    path[rows-1] = col;
    for (i = rows - 1; i > 0; i--) begin
      bp = ptrs[i*LIM_COLS + col];
      if (bp == msdp_pkg::BP_LEFT && col > 0) col--;
      else if (bp == msdp_pkg::BP_RIGHT && col + 1 < cols) col++;
      path[i-1] = col;
    end
    for (i = 0; i < rows; i++) begin
      rec.row   = msdp_pkg::ROW_W'(i);
      rec.col   = msdp_pkg::COLF_W'(path[i]);
      rec.total = msdp_pkg::SUM_W'(sum);
      rec.last  = (i + 1 == rows);
      seam_q.push_back(rec);
    end
  endfunction

  // Driver: hold a pixel until accepted, insert random idle bursts early on.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_pixel(in_pixel_cost);
        pixels_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          if (pixels_taken < QUIET_AT && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 14) - 1;
            start <= 1'b0;
          end else begin
            in_pixel_cost <= pixel_q.pop_front();
            start <= 1'b1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed row against the oldest queued expectation.
  always @(posedge clk) begin
    seam_row_t exp_row;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid) begin
        if (seam_q.size() == 0) begin
          if (errors < 10) $display("unexpected seam row %0d col %0d", out_row_number,
                                    out_seam_column);
          errors++;
        end else begin
          exp_row = seam_q.pop_front();
          if (exp_row.row !== out_row_number || exp_row.col !== out_seam_column ||
              exp_row.total !== out_total_cost || exp_row.last !== out_last_of_seam) begin
            if (errors < 10)
              $display("seam mismatch: exp row %0d col %0d cost %0d last %0b, got %0d %0d %0d %0b",
                       exp_row.row, exp_row.col, exp_row.total, exp_row.last, out_row_number,
                       out_seam_column, out_total_cost, out_last_of_seam);
            errors++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drain pending pixels and seams, then give the block time to finish its row copy.
  task automatic settle();
    while (pixel_q.size() > 0 || start || gap_left > 0 || seam_q.size() > 0) @(posedge clk);
    repeat (LIM_COLS + 40) @(posedge clk);
  endtask

  // Write one register while the block is idle; a write drops the image in progress.
  task automatic cfg_write(logic idx, logic [msdp_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == msdp_pkg::CFG_COLS) cols_reg = val;
    else rows_reg = val[5:0];
    row_pos = 0;
    col_pos = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Queue n pixels of one flavor: full range, tie-heavy, near max, or zero.
  task automatic push_pixels(int unsigned n, int unsigned flavor);
    for (int unsigned i = 0; i < n; i++) begin
      case (flavor)
        0: pixel_q.push_back(16'($urandom));
        1: pixel_q.push_back(16'($urandom_range(0, 3)));
        2: pixel_q.push_back(16'($urandom_range(65530, 65535)));
        default: pixel_q.push_back(16'd0);
      endcase
      pixels_pushed++;
    end
  endtask

  task automatic run_image(int unsigned flavor);
    push_pixels(cols_now() * rows_now(), flavor);
    settle();
  endtask

  initial begin
    int unsigned pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest image, with saturation from below on both registers
    cfg_write(msdp_pkg::CFG_COLS, 7'd1);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd0);
    pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    pixels_pushed += 2;
    settle();
    // equal costs: every choice is a tie, leftmost wins
    cfg_write(msdp_pkg::CFG_COLS, 7'd3);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd3);
    for (int i = 0; i < 9; i++) pixel_q.push_back(16'd5);
    pixels_pushed += 9;
    settle();
    // cost extremes on a 2x2 image
    cfg_write(msdp_pkg::CFG_COLS, 7'd2);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd2);
    pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'h0000); pixel_q.push_back(16'hFFFF);
    pixels_pushed += 4;
    settle();
    // abandon a half-fed image by a register write
    cfg_write(msdp_pkg::CFG_COLS, 7'd4);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd3);
    push_pixels(6, 0);
    settle();
    cfg_write(msdp_pkg::CFG_ROWS, 7'd2);
    run_image(1);

    // widest row (saturated from above), then tallest column pair
    cfg_write(msdp_pkg::CFG_COLS, 7'd127);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd1);
    run_image(0);
    cfg_write(msdp_pkg::CFG_COLS, 7'd2);
    cfg_write(msdp_pkg::CFG_ROWS, 7'd63);
    run_image(0);

    // random small images until the pixel budget is spent
    while (pixels_pushed < 410) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) cfg_write(msdp_pkg::CFG_COLS, 7'($urandom_range(65, 127)));
      else cfg_write(msdp_pkg::CFG_COLS, 7'($urandom_range(2, 8)));
      if (pick == 1) cfg_write(msdp_pkg::CFG_ROWS, 7'($urandom_range(33, 63)));
      else if ($urandom_range(0, 3) != 0)
        cfg_write(msdp_pkg::CFG_ROWS, 7'($urandom_range(1, 6)));
      if (cols_now() * rows_now() > 64) cfg_write(msdp_pkg::CFG_ROWS, 7'd1);
      run_image($urandom_range(0, 4) == 4 ? 3 : $urandom_range(0, 2));
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
